FILE: src/lcdfe_pkg.sv
// Shared types, op codes, LCD command bytes and the Cyrillic recode table.
`timescale 1ns / 1ps
`default_nettype none

package lcdfe_pkg;

	// Geometry defaults and limits
	localparam int DEF_NUM_ROWS    = 2;
	localparam int DEF_NUM_COLS    = 16;
	localparam int MAX_NUM_COLS    = 40;
	localparam int DEF_QUEUE_DEPTH = 2;

	// Cursor column holds 0..NUM_COLS for any allowed geometry
	localparam int CUR_COL_W = $clog2(MAX_NUM_COLS + 1);

	// Input op codes
	localparam logic [2:0] OP_PUT_CHAR = 3'd0;
	localparam logic [2:0] OP_CLEAR    = 3'd1;
	localparam logic [2:0] OP_SET_POS  = 3'd2;
	localparam logic [2:0] OP_CURSOR   = 3'd3;
	localparam logic [2:0] OP_INIT     = 3'd4;

	// LCD command bytes
	localparam logic [7:0] LCD_FUNCTION_SET = 8'h3C;
	localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] LCD_CLR_HOME     = 8'h01;
	localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;

	// Init sequence steps (steps before DISP send the function set)
	localparam logic [2:0] INIT_STEP_DISP  = 3'd2;
	localparam logic [2:0] INIT_STEP_CLEAR = 3'd3;
	localparam logic [2:0] INIT_STEP_ENTRY = 3'd4;

	// Classified operation handed from front to back
	typedef enum logic [2:0] {
		KIND_CHAR,
		KIND_CLEAR,
		KIND_POS,
		KIND_MODE,
		KIND_INIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [7:0]             byte_val;  // recoded char, clear, mode or position command
		logic                   row;       // clamped row for set position
		logic [CUR_COL_W-1:0]   col;       // clamped column for set position
	} cmd_t;

	// Codes 192..255 map to the controller's Cyrillic glyphs
	localparam logic [7:0] CYR_ROM [64] = '{
		8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'h33,
		8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
		8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
		8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
		8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
		8'hB8, 8'hA6, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
		8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'hD5, 8'hE5, 8'hC0,
		8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
	};

endpackage

`default_nettype wire

FILE: src/lcdfe_front.sv
// Front end: accepts input beats, drops unknown ops and classifies the rest.
`timescale 1ns / 1ps
`default_nettype none

module lcdfe_front
	import lcdfe_pkg::*;
#(
	parameter int NUM_ROWS = DEF_NUM_ROWS,
	parameter int NUM_COLS = DEF_NUM_COLS
) (
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] op,
	input  wire logic [7:0] char_code,
	input  wire logic [7:0] row_req,
	input  wire logic [7:0] col_req,
	input  wire logic [7:0] cursor_mode,
	input  wire logic       queue_full,
	output logic            push,
	output cmd_t            push_cmd
);

	logic                 known_op;
	logic                 row_clamp;
	logic [CUR_COL_W-1:0] col_clamp;
	logic [1:0]           mode_bits;
	logic [7:0]           char_recoded;

	// Hold input while the queue has no room
	assign in_stall = queue_full;

	// Clamp the requested position to the display
	assign row_clamp = (row_req > 8'(NUM_ROWS - 1)) ? 1'(NUM_ROWS - 1) : row_req[0];
	assign col_clamp = (col_req > 8'(NUM_COLS - 1)) ? CUR_COL_W'(NUM_COLS - 1)
		: col_req[CUR_COL_W-1:0];

	// Fold undefined cursor modes onto cursor on, no blink
	assign mode_bits = (cursor_mode > 8'd3) ? 2'd2 : cursor_mode[1:0];

	// Recode the upper quarter of the code space through the glyph table
	assign char_recoded = (char_code[7:6] == 2'b11) ? CYR_ROM[char_code[5:0]] : char_code;

	// Classify the op
	always_comb begin
		known_op          = 1'b1;
		push_cmd.kind     = KIND_CHAR;
		push_cmd.byte_val = char_recoded;
		push_cmd.row      = row_clamp;
		push_cmd.col      = col_clamp;
		case (op)
			OP_PUT_CHAR: begin
				push_cmd.kind = KIND_CHAR;
			end
			OP_CLEAR: begin
				push_cmd.kind     = KIND_CLEAR;
				push_cmd.byte_val = LCD_CLR_HOME;
			end
			OP_SET_POS: begin
				push_cmd.kind     = KIND_POS;
				push_cmd.byte_val = {1'b1, row_clamp, col_clamp[5:0]};
			end
			OP_CURSOR: begin
				push_cmd.kind     = KIND_MODE;
				push_cmd.byte_val = LCD_DISPLAY_ON | {6'b0, mode_bits};
			end
			OP_INIT: begin
				push_cmd.kind = KIND_INIT;
			end
			default: begin
				known_op = 1'b0;
			end
		endcase
	end

	// Unknown ops are taken and dropped
	assign push = in_valid && !queue_full && known_op;

endmodule

`default_nettype wire

FILE: src/lcdfe_queue.sv
// Short command queue between the classifying front and the byte sequencer.
`timescale 1ns / 1ps
`default_nettype none

module lcdfe_queue
	import lcdfe_pkg::*;
#(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      head_valid,
	output cmd_t      head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t            entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: src/lcdfe_back.sv
// Back end: keeps the cursor and expands queued commands into LCD bus beats.
`timescale 1ns / 1ps
`default_nettype none

module lcdfe_back
	import lcdfe_pkg::*;
#(
	parameter int NUM_ROWS = DEF_NUM_ROWS,
	parameter int NUM_COLS = DEF_NUM_COLS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic head_valid,
	input  wire cmd_t head,
	output logic      pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [7:0] bus_byte,
	output logic       is_data,
	output logic       last,
	output logic       cur_row,
	output logic [4:0] cur_col
);

	logic                 row_q;
	logic [CUR_COL_W-1:0] col_q;
	logic [2:0]           step_q;
	logic                 out_valid_q;
	logic [7:0]           bus_byte_q;
	logic                 is_data_q;
	logic                 last_q;
	logic                 cur_row_q;
	logic [4:0]           cur_col_q;

	logic                 out_free;
	logic                 fire;
	logic                 wrap;
	logic                 row_n;
	logic [CUR_COL_W-1:0] col_n;
	logic [7:0]           byte_n;
	logic                 data_n;
	logic                 done_n;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = head_valid && out_free;
	assign pop      = fire && done_n;
	assign wrap     = (col_q >= CUR_COL_W'(NUM_COLS));

	// Work out the next beat and cursor for the head command
	always_comb begin
		row_n  = row_q;
		col_n  = col_q;
		byte_n = head.byte_val;
		data_n = 1'b0;
		done_n = 1'b1;
		case (head.kind)
			KIND_CHAR: begin
				if (wrap) begin
					// Move to the start of the next row, or home from the last row
					row_n  = (row_q == 1'(NUM_ROWS - 1)) ? 1'b0 : row_q + 1'b1;
					col_n  = '0;
					byte_n = {1'b1, row_n, 6'b0};
					done_n = 1'b0;
				end else begin
					col_n  = col_q + 1'b1;
					data_n = 1'b1;
				end
			end
			KIND_CLEAR: begin
				row_n = 1'b0;
				col_n = '0;
			end
			KIND_POS: begin
				row_n = head.row;
				col_n = head.col;
			end
			KIND_MODE: begin
				byte_n = head.byte_val;
			end
			KIND_INIT: begin
				done_n = 1'b0;
				case (step_q)
					INIT_STEP_DISP: begin
						byte_n = LCD_DISPLAY_ON;
					end
					INIT_STEP_CLEAR: begin
						byte_n = LCD_CLR_HOME;
						row_n  = 1'b0;
						col_n  = '0;
					end
					INIT_STEP_ENTRY: begin
						byte_n = LCD_ENTRY_MODE;
						done_n = 1'b1;
					end
					default: begin
						byte_n = LCD_FUNCTION_SET;
					end
				endcase
			end
			default: begin
				done_n = 1'b1;
			end
		endcase
	end

	// Advance cursor, init step and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= 1'b0;
			col_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= fire;
			end
			if (fire) begin
				row_q <= row_n;
				col_q <= col_n;
				if (head.kind == KIND_INIT && !done_n) begin
					step_q <= step_q + 1'b1;
				end else begin
					step_q <= '0;
				end
			end
		end
	end

	// Load the output beat
	always_ff @(posedge clk) begin
		if (fire) begin
			bus_byte_q <= byte_n;
			is_data_q  <= data_n;
			last_q     <= done_n;
			cur_row_q  <= row_n;
			cur_col_q  <= col_n[4:0];
		end
	end

	assign out_valid = out_valid_q;
	assign bus_byte  = bus_byte_q;
	assign is_data   = is_data_q;
	assign last      = last_q;
	assign cur_row   = cur_row_q;
	assign cur_col   = cur_col_q;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= CUR_COL_W'(NUM_COLS))
		else $error("cursor column beyond display width");

	a_step_init_only: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) |-> (head_valid && head.kind == KIND_INIT))
		else $error("init step left over without an init command");

	a_wrap_then_char: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && head.kind == KIND_CHAR && wrap) |=> (head_valid && !wrap))
		else $error("put char wrap not followed by its character");

endmodule

`default_nettype wire

FILE: src/char_lcd_text_front_end.sv
// Top level of the character LCD text front end.
`timescale 1ns / 1ps
`default_nettype none

// Turns text operations (put char, clear, set position, cursor mode, init)
// into command and data beats for a character LCD bus, keeping the
// cursor row and column. The front end takes one input beat per cycle into a
// short command queue while it has room; the back end sends one bus beat per
// cycle from its output register while the bus does not stall. An operation
// has one bus beat for clear, set position and cursor mode, one or two for put
// char (two when the column has run past the display width) and five for init.
// Unknown ops are taken and produce nothing. The first beat of an operation
// passes through the queue and then the back end's output register. Delays,
// busy-flag polling and pin strobing are left to the bus driver downstream.
module char_lcd_text_front_end
	import lcdfe_pkg::*;
#(
	parameter int NUM_ROWS    = DEF_NUM_ROWS,
	parameter int NUM_COLS    = DEF_NUM_COLS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] op,
	input  wire logic [7:0] char_code,
	input  wire logic [7:0] row_req,
	input  wire logic [7:0] col_req,
	input  wire logic [7:0] cursor_mode,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      bus_byte,
	output logic            is_data,
	output logic            last,
	output logic            cur_row,
	output logic [4:0]      cur_col
);

	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic pop;
	logic head_valid;
	cmd_t head;

	lcdfe_front #(
		.NUM_ROWS (NUM_ROWS),
		.NUM_COLS (NUM_COLS)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.char_code   (char_code),
		.row_req     (row_req),
		.col_req     (col_req),
		.cursor_mode (cursor_mode),
		.queue_full  (queue_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	lcdfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	lcdfe_back #(
		.NUM_ROWS (NUM_ROWS),
		.NUM_COLS (NUM_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.bus_byte   (bus_byte),
		.is_data    (is_data),
		.last       (last),
		.cur_row    (cur_row),
		.cur_col    (cur_col)
	);

endmodule

`default_nettype wire
